// ===== src/ltsi_pkg.sv =====
// Package for the log axis subtick interpolator.
// Holds shared constants, the datapath operation codes and the control/status structs.
// No dependencies.
package ltsi_pkg;

  // Default parameter values.
  localparam int MAX_SUBTICKS_DEF = 16;
  localparam int POS_WIDTH_DEF    = 32;
  localparam int FRAC_BITS_DEF    = 22;

  // Fixed field widths.
  localparam int CFG_W = 5;
  localparam int IDX_W = 4;

  // Arithmetic constants.
  localparam logic [30:0] Q30_ONE       = 31'h4000_0000;
  localparam logic [29:0] K_LOG2_10_Q28 = 30'd891723283;
  localparam logic [29:0] K_LN2_Q30     = 30'd744261118;
  localparam logic [28:0] K_LOG10_2_Q30 = 29'd323228497;
  localparam int          TAYLOR_TERMS  = 14;
  localparam int          SQ_STEPS      = 30;
  localparam int          EXP_K_LIMIT   = 31;

  // Operation the datapath performs in the current cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EXPL,
    OP_EXPX,
    OP_TMUL,
    OP_TDIV,
    OP_TACC,
    OP_EXPF,
    OP_HMUL,
    OP_HDIV,
    OP_NORM,
    OP_SQR,
    OP_MAG
  } op_t;

  typedef struct packed {
    op_t  op;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic has_work;
    logic div_done;
    logic tay_last;
    logic norm_ok;
    logic sq_last;
    logic j_last;
  } stat_t;

endpackage

// ===== src/ltsi_if.sv =====
// Valid/ready channel interfaces for tick input and subtick output items.
// Depends on ltsi_pkg for default widths.
interface ltsi_in_if #(
  parameter int POS_WIDTH = ltsi_pkg::POS_WIDTH_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] tick_position;
  logic                        last_tick;

  modport source (output valid, tick_position, last_tick, input ready);
  modport sink   (input valid, tick_position, last_tick, output ready);
endinterface

interface ltsi_out_if #(
  parameter int POS_WIDTH = ltsi_pkg::POS_WIDTH_DEF
) ();
  import ltsi_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] subtick_position;
  logic [IDX_W-1:0]            subtick_index;
  logic                        last_of_run;

  modport source (output valid, subtick_position, subtick_index, last_of_run, input ready);
  modport sink   (input valid, subtick_position, subtick_index, last_of_run, output ready);
endinterface

// ===== src/ltsi_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Used by the datapath for the Taylor term and subtick fraction divisions.
module ltsi_div #(
  parameter int DW = 36,
  parameter int VW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] count_r;
  logic          busy_r;
  logic          done_r;
  logic [DW-1:0] q_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [VW:0]   rem_sh;
  logic          fits;

  // Shift in the next dividend bit and try a subtract.
  assign rem_sh = {rem_r, q_r[DW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else if (start) begin
      busy_r  <= 1'b1;
      done_r  <= 1'b0;
      count_r <= CW'(DW);
    end else if (busy_r) begin
      count_r <= count_r - 1'b1;
      if (count_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= VW'(rem_sh - {1'b0, dvs_r});
        q_r   <= {q_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[VW-1:0];
        q_r   <= {q_r[DW-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== src/ltsi_dp.sv =====
// Datapath: tick state, iterative 10^-d series, fraction divide, log10 by squaring.
// Depends on ltsi_pkg and ltsi_div; driven by ltsi_ctrl through cmd_t/stat_t.
module ltsi_dp #(
  parameter int MAX_SUBTICKS = ltsi_pkg::MAX_SUBTICKS_DEF,
  parameter int POS_WIDTH    = ltsi_pkg::POS_WIDTH_DEF,
  parameter int FRAC_BITS    = ltsi_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ltsi_pkg::cmd_t                cmd,
  output ltsi_pkg::stat_t               stat,
  input  logic signed [POS_WIDTH-1:0]   tick_position,
  input  logic                          last_tick,
  input  logic                          cfg_we,
  input  logic [ltsi_pkg::CFG_W-1:0]    cfg_data,
  output logic signed [POS_WIDTH-1:0]   subtick_position,
  output logic [ltsi_pkg::IDX_W-1:0]    subtick_index,
  output logic                          last_of_run
);
  import ltsi_pkg::*;

  localparam int CNT_W = $clog2(MAX_SUBTICKS + 2);
  localparam int VW    = (CNT_W > 4) ? CNT_W : 4;
  localparam int DW    = CNT_W + 31;
  localparam int SH    = 30 - FRAC_BITS;
  localparam int LM_W  = (POS_WIDTH + 1 > FRAC_BITS + 5) ? POS_WIDTH + 1 : FRAC_BITS + 5;
  localparam int EXT_W = ((POS_WIDTH > 36) ? POS_WIDTH : 36) + 2;
  localparam logic [35:0] HALF = 36'((36'd1 << SH) >> 1);

  // Architectural state and per-item registers.
  logic [CFG_W-1:0]            cfg_r;
  logic signed [POS_WIDTH-1:0] prev_r;
  logic                        have_prev_r;
  logic signed [POS_WIDTH-1:0] base_r;
  logic                        up_r;
  logic [POS_WIDTH:0]          dmag_r;
  logic [CNT_W-1:0]            n_r;
  logic [CNT_W-1:0]            j_r;
  logic [4:0]                  k_r;
  logic [29:0]                 r_r;
  logic                        wide_r;
  logic [29:0]                 x_r;
  logic [30:0]                 t_r;
  logic signed [32:0]          acc_r;
  logic [3:0]                  tn_r;
  logic [30:0]                 e_r;
  logic [30:0]                 h_r;
  logic [4:0]                  s_r;
  logic [29:0]                 y_r;
  logic [4:0]                  i_r;
  logic signed [POS_WIDTH-1:0] pos_r;
  logic [IDX_W-1:0]            idx_r;
  logic                        lor_r;

  // Combinational helpers.
  logic [CNT_W-1:0]            n_eff;
  logic signed [POS_WIDTH:0]   d_full;
  logic [LM_W-1:0]             dm_ext;
  logic [FRAC_BITS+34:0]       lprod;
  logic [64:0]                 lsh;
  logic [6:0]                  kk;
  logic [59:0]                 xprod;
  logic [60:0]                 tprod;
  logic [CNT_W-1:0]            a_cnt;
  logic [CNT_W-1:0]            b_cnt;
  logic [CNT_W+30:0]           be;
  logic [DW-1:0]               num;
  logic                        div_start;
  logic [DW-1:0]               div_dvd;
  logic [VW-1:0]               div_dvs;
  logic                        div_done;
  logic [DW-1:0]               div_q;
  logic signed [32:0]          acc_nxt;
  logic [30:0]                 acc_cl;
  logic [61:0]                 sq;
  logic [31:0]                 sqs;
  logic [33:0]                 sk;
  logic [58:0]                 yk;
  logic [58:0]                 yk_up;
  logic [35:0]                 mag30;
  logic [35:0]                 magr;
  logic signed [EXT_W-1:0]     pos_ext;
  logic                        pos_ovf;

  // Subtick count, clamped to the supported maximum.
  assign n_eff = (int'(cfg_r) > MAX_SUBTICKS) ? CNT_W'(MAX_SUBTICKS) : CNT_W'(cfg_r);

  // Tick difference and its magnitude.
  assign d_full = {tick_position[POS_WIDTH-1], tick_position} - {prev_r[POS_WIDTH-1], prev_r};

  // Scale the decade count to a power-of-two exponent: integer part k, fraction r.
  assign dm_ext = LM_W'(dmag_r);
  assign lprod  = dm_ext[FRAC_BITS+4:0] * K_LOG2_10_Q28;
  assign lsh    = 65'(lprod) << SH;
  assign kk     = lsh[64:58];

  assign xprod = r_r * K_LN2_Q30;
  assign tprod = t_r * x_r;

  // Linear weights of the current and previous tick for subtick j.
  assign a_cnt = up_r ? CNT_W'(j_r + 1'b1) : CNT_W'(n_r - j_r);
  assign b_cnt = up_r ? CNT_W'(n_r - j_r) : CNT_W'(j_r + 1'b1);
  assign be    = b_cnt * e_r;
  assign num   = (DW'(a_cnt) << 30) + DW'(be);

  // Shared divider operands.
  assign div_start = (cmd.op == OP_TMUL) || (cmd.op == OP_HMUL);
  assign div_dvd   = (cmd.op == OP_TMUL) ? DW'(tprod[60:30]) : num;
  assign div_dvs   = (cmd.op == OP_TMUL) ? VW'(tn_r) : VW'(n_r + 1'b1);

  ltsi_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // Series accumulate and clamp to [0, 1].
  assign acc_nxt = tn_r[0] ? acc_r - $signed({2'b00, t_r}) : acc_r + $signed({2'b00, t_r});
  assign acc_cl  = acc_r[32] ? 31'd0 :
                   (acc_r > $signed({2'b00, Q30_ONE})) ? Q30_ONE : acc_r[30:0];

  // One squaring step of the log2 bit extraction.
  assign sq  = h_r * h_r;
  assign sqs = sq[61:30];

  // Convert log2 to log10 magnitude and round to the output precision.
  assign sk     = s_r * K_LOG10_2_Q30;
  assign yk     = y_r * K_LOG10_2_Q30;
  assign yk_up  = yk + 59'h3FFF_FFFF;
  assign mag30  = 36'(sk) - 36'(yk_up[58:30]);
  assign magr   = (mag30 + HALF) >> SH;
  assign pos_ext = EXT_W'(base_r) - $signed({1'b0, (EXT_W-1)'(magr)});
  assign pos_ovf = (pos_ext[EXT_W-1:POS_WIDTH-1] != '0) &&
                   (pos_ext[EXT_W-1:POS_WIDTH-1] != '1);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      cfg_r <= cfg_data;
    end
  end

  // Previous tick state, updated as each item is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      have_prev_r <= 1'b0;
    end else if (cmd.op == OP_LOAD) begin
      prev_r      <= last_tick ? '0 : tick_position;
      have_prev_r <= !last_tick;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        up_r   <= !d_full[POS_WIDTH];
        dmag_r <= d_full[POS_WIDTH] ? (POS_WIDTH+1)'(-d_full) : d_full;
        base_r <= d_full[POS_WIDTH] ? prev_r : tick_position;
        n_r    <= n_eff;
        j_r    <= '0;
      end
      OP_EXPL: begin
        r_r    <= lsh[57:28];
        k_r    <= kk[4:0];
        wide_r <= (dm_ext > (LM_W'(16) << FRAC_BITS)) || (kk >= 7'(EXP_K_LIMIT));
      end
      OP_EXPX: begin
        x_r   <= xprod[59:30];
        t_r   <= Q30_ONE;
        acc_r <= 33'(Q30_ONE);
        tn_r  <= 4'd1;
      end
      OP_TDIV: begin
        if (div_done) begin
          t_r <= div_q[30:0];
        end
      end
      OP_TACC: begin
        acc_r <= acc_nxt;
        tn_r  <= tn_r + 1'b1;
      end
      OP_EXPF: begin
        e_r <= wide_r ? 31'd0 : (acc_cl >> k_r);
      end
      OP_HDIV: begin
        if (div_done) begin
          h_r <= (div_q == '0) ? 31'd1 : div_q[30:0];
          s_r <= '0;
          y_r <= '0;
          i_r <= '0;
        end
      end
      OP_NORM: begin
        if (!h_r[30]) begin
          h_r <= {h_r[29:0], 1'b0};
          s_r <= s_r + 1'b1;
        end
      end
      OP_SQR: begin
        h_r <= sqs[31] ? sqs[31:1] : sqs[30:0];
        y_r <= {y_r[28:0], sqs[31]};
        i_r <= i_r + 1'b1;
      end
      OP_MAG: begin
        if (pos_ovf) begin
          pos_r <= pos_ext[EXT_W-1] ? {1'b1, {(POS_WIDTH-1){1'b0}}}
                                    : {1'b0, {(POS_WIDTH-1){1'b1}}};
        end else begin
          pos_r <= pos_ext[POS_WIDTH-1:0];
        end
        idx_r <= IDX_W'(j_r);
        lor_r <= (j_r == CNT_W'(n_r - 1'b1));
      end
      default: begin
      end
    endcase
    if (cmd.pop) begin
      j_r <= j_r + 1'b1;
    end
  end

  // Status back to the controller.
  assign stat.has_work = have_prev_r && (n_eff != '0);
  assign stat.div_done = div_done;
  assign stat.tay_last = (tn_r == 4'(TAYLOR_TERMS));
  assign stat.norm_ok  = h_r[30];
  assign stat.sq_last  = (i_r == 5'(SQ_STEPS - 1));
  assign stat.j_last   = (j_r == CNT_W'(n_r - 1'b1));

  assign subtick_position = pos_r;
  assign subtick_index    = idx_r;
  assign last_of_run      = lor_r;

endmodule

// ===== src/ltsi_ctrl.sv =====
// Controller state machine sequencing one tick item through the datapath.
// Depends on ltsi_pkg; issues cmd_t to ltsi_dp and reads back stat_t.
module ltsi_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ltsi_pkg::stat_t stat,
  output ltsi_pkg::cmd_t  cmd
);
  import ltsi_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_EXPL = 13'b0000000000010,
    S_EXPX = 13'b0000000000100,
    S_TMUL = 13'b0000000001000,
    S_TDIV = 13'b0000000010000,
    S_TACC = 13'b0000000100000,
    S_EXPF = 13'b0000001000000,
    S_HMUL = 13'b0000010000000,
    S_HDIV = 13'b0000100000000,
    S_NORM = 13'b0001000000000,
    S_SQR  = 13'b0010000000000,
    S_MAG  = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    cmd.pop   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = stat.has_work ? S_EXPL : S_IDLE;
        end
      end
      S_EXPL: begin
        cmd.op    = OP_EXPL;
        state_nxt = S_EXPX;
      end
      S_EXPX: begin
        cmd.op    = OP_EXPX;
        state_nxt = S_TMUL;
      end
      S_TMUL: begin
        cmd.op    = OP_TMUL;
        state_nxt = S_TDIV;
      end
      S_TDIV: begin
        cmd.op = OP_TDIV;
        if (stat.div_done) begin
          state_nxt = S_TACC;
        end
      end
      S_TACC: begin
        cmd.op    = OP_TACC;
        state_nxt = stat.tay_last ? S_EXPF : S_TMUL;
      end
      S_EXPF: begin
        cmd.op    = OP_EXPF;
        state_nxt = S_HMUL;
      end
      S_HMUL: begin
        cmd.op    = OP_HMUL;
        state_nxt = S_HDIV;
      end
      S_HDIV: begin
        cmd.op = OP_HDIV;
        if (stat.div_done) begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        cmd.op = OP_NORM;
        if (stat.norm_ok) begin
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        cmd.op = OP_SQR;
        if (stat.sq_last) begin
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        cmd.op    = OP_MAG;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.pop   = 1'b1;
          state_nxt = stat.j_last ? S_IDLE : S_HMUL;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

// ===== src/log_axis_subtick_interpolator.sv =====
// Log axis subtick interpolator: takes major tick positions (signed log10, Q.FRAC_BITS) and
// emits N subticks per interval, evenly spaced in linear space. One item is worked at a time.
// A tick that yields no subticks is taken in the cycle it is offered. Otherwise 10^-|d| is
// summed over 14 Taylor terms through the shared bit-serial divider (DW = 36 by default), and
// each subtick then takes one divide, at most 5 normalize shifts because the fraction is
// never below 1/(N+1), and 30 squarings, plus any output stall. The output register holds
// a result until it is taken; the next tick is accepted once the last subtick has left.
// Depends on ltsi_pkg, ltsi_if, ltsi_div, ltsi_dp and ltsi_ctrl.
module log_axis_subtick_interpolator #(
  parameter int MAX_SUBTICKS = ltsi_pkg::MAX_SUBTICKS_DEF,
  parameter int POS_WIDTH    = ltsi_pkg::POS_WIDTH_DEF,
  parameter int FRAC_BITS    = ltsi_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ltsi_in_if.sink                    in_s,
  ltsi_out_if.source                 out_m,
  input  logic                       cfg_we,
  input  logic [ltsi_pkg::CFG_W-1:0] cfg_data
);
  import ltsi_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  ltsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_s.valid),
    .in_ready  (in_s.ready),
    .out_valid (out_m.valid),
    .out_ready (out_m.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  ltsi_dp #(
    .MAX_SUBTICKS (MAX_SUBTICKS),
    .POS_WIDTH    (POS_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .tick_position    (in_s.tick_position),
    .last_tick        (in_s.last_tick),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .subtick_position (out_m.subtick_position),
    .subtick_index    (out_m.subtick_index),
    .last_of_run      (out_m.last_of_run)
  );

  // A result on offer means no new tick can be taken.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_m.valid |-> !in_s.ready)
    else $error("input ready while a result is pending");

  // After the last subtick of a run leaves, the block is ready for the next tick.
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_m.valid && out_m.ready && out_m.last_of_run |=> in_s.ready)
    else $error("block not idle after final subtick");

  // A further subtick of the same run needs fresh computation first.
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_m.valid && out_m.ready && !out_m.last_of_run |=> !out_m.valid && !in_s.ready)
    else $error("subtick reissued without computation");

endmodule

// ===== sim/tb_log_axis_subtick_interpolator.sv =====
// Testbench for the log axis subtick interpolator: directed ticks from a table, then random
// tick sets, with a built-in fixed point predictor checking every subtick item in order.
// Depends on ltsi_pkg, ltsi_if and the log_axis_subtick_interpolator RTL.
module tb_log_axis_subtick_interpolator;
  import ltsi_pkg::*;

  localparam int PW = POS_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;

  typedef struct {
    logic signed [PW-1:0] pos;
    logic [IDX_W-1:0]     idx;
    logic                 last;
  } subtick_t;

  typedef struct {
    logic signed [PW-1:0] pos;
    logic                 last;
    logic                 chk;
    logic signed [PW-1:0] want;
  } tick_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_data;

  ltsi_in_if  #(.POS_WIDTH(PW)) in_ch ();
  ltsi_out_if #(.POS_WIDTH(PW)) out_ch ();

  log_axis_subtick_interpolator u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_s    (in_ch),
    .out_m   (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  // Predictor state, mirrors the block's register and tick memory.
  logic [CFG_W-1:0]     pred_count_reg;
  logic signed [PW-1:0] pred_prev_tick;
  logic                 pred_have_prev;

  subtick_t expected_subticks[$];
  int       err_count;
  logic     chk_first;
  logic signed [PW-1:0] chk_first_pos;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  initial begin
    #60000000;
    $display("FAIL log_axis_subtick_interpolator");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // 2^-r for an unsigned Q30 fraction r, result Q30.
  function automatic logic [63:0] exp2_frac_q30(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] term;
    longint      acc;
    x = (r * 64'd744261118) >> 30;
    term = 64'd1 << 30;
    acc = 64'sd1 << 30;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * x) >> 30) / n;
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
    return 64'(acc);
  endfunction

  // 10^-D for D in Q.FB, result Q30; wide intervals give 0.
  function automatic logic [63:0] pow10_neg_q30(input logic [63:0] dmag);
    logic [63:0] l;
    logic [63:0] k;
    if (dmag > (64'd16 << FB)) return 0;
    l = ((dmag << (30 - FB)) * 64'd891723283) >> 28;
    k = l >> 30;
    if (k >= 31) return 0;
    return exp2_frac_q30(l & ((64'd1 << 30) - 1)) >> k;
  endfunction

  // -log10(h) for Q30 h in (0, 1], result Q.FB rounded half up.
  function automatic logic [63:0] neg_log10_q(input logic [63:0] h);
    logic [63:0] s;
    logic [63:0] y;
    logic [63:0] m30;
    s = 0;
    y = 0;
    if (h == 0) h = 1;
    while (h < (64'd1 << 30)) begin
      h = h << 1;
      s++;
    end
    for (int i = 0; i < 30; i++) begin
      h = (h * h) >> 30;
      if (h >= (64'd1 << 31)) begin
        h = h >> 1;
        y |= 64'd1 << (29 - i);
      end
    end
    m30 = (((s << 30) - y) * 64'd323228497) >> 30;
    return (m30 + ((64'd1 << (30 - FB)) >> 1)) >> (30 - FB);
  endfunction

  // Queue the subticks one tick causes, then update the tick memory.
  task automatic predict_subticks(input logic signed [PW-1:0] cur, input logic last);
    longint      n;
    longint      d;
    longint      pos;
    longint      pmax;
    logic        up;
    logic [63:0] e;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] h;
    subtick_t    st;
    pmax = (64'sd1 <<< (PW - 1)) - 1;
    n = pred_count_reg > MAX_SUBTICKS_DEF ? MAX_SUBTICKS_DEF : pred_count_reg;
    if (pred_have_prev && n > 0) begin
      d = longint'(cur) - longint'(pred_prev_tick);
      up = d >= 0;
      e = pow10_neg_q30(up ? 64'(d) : 64'(-d));
      for (longint j = 0; j < n; j++) begin
        a = up ? 64'(j + 1) : 64'(n - j);
        b = up ? 64'(n - j) : 64'(j + 1);
        h = ((a << 30) + b * e) / 64'(n + 1);
        pos = (up ? longint'(cur) : longint'(pred_prev_tick)) - longint'(neg_log10_q(h));
        if (pos > pmax) pos = pmax;
        if (pos < -pmax - 1) pos = -pmax - 1;
        st.pos = PW'(pos);
        st.idx = IDX_W'(j);
        st.last = (j + 1 == n);
        expected_subticks.push_back(st);
      end
    end
    pred_have_prev = !last;
    pred_prev_tick = last ? '0 : cur;
  endtask

  // Send one tick item, with a random gap before it when a new burst starts.
  int burst_left;
  task automatic send_tick(input logic signed [PW-1:0] pos, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.tick_position <= pos;
    in_ch.last_tick <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_subticks(pos, last);
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
  endtask

  // Wait for every queued subtick, then the tail latency, then write the register.
  task automatic write_count(input logic [CFG_W-1:0] value);
    drop_valid();
    @(posedge clk);
    while (expected_subticks.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    pred_count_reg = value;
  endtask

  // Receiver: stall pattern plus result checking.
  int stall_mode;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_subticks.size() == 0) begin
          report_mismatch($sformatf("unexpected subtick pos=%0d", out_ch.subtick_position));
        end else begin
          subtick_t w;
          w = expected_subticks.pop_front();
          if (chk_first) begin
            chk_first <= 1'b0;
            if (out_ch.subtick_position !== chk_first_pos)
              report_mismatch($sformatf("directed pos %0d want %0d",
                out_ch.subtick_position, chk_first_pos));
          end
          if (out_ch.subtick_position !== w.pos || out_ch.subtick_index !== w.idx ||
              out_ch.last_of_run !== w.last)
            report_mismatch($sformatf("got pos=%0d idx=%0d last=%0b want %0d/%0d/%0b",
              out_ch.subtick_position, out_ch.subtick_index, out_ch.last_of_run,
              w.pos, w.idx, w.last));
        end
      end
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Directed ticks; the first subtick of the whole-decade pair is typed in.
  localparam int N_DIR = 14;
  tick_row_t dir_rows[N_DIR];

  initial begin
    int last_pos;
    int n_res;
    logic signed [PW-1:0] p;
    err_count = 0;
    burst_left = 0;
    stall_mode = 0;
    chk_first = 1'b0;
    chk_first_pos = '0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.tick_position = '0;
    in_ch.last_tick = 1'b0;
    pred_count_reg = '0;
    pred_prev_tick = '0;
    pred_have_prev = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset N is 0: no subticks at all.
    send_tick(32'sd4194304, 1'b0);
    send_tick(32'sd8388608, 1'b1);

    // One subtick, whole decade up from 0 to 1: midpoint log10(5.5) in Q22.
    dir_rows[0] = '{32'sd0, 1'b0, 1'b0, '0};
    dir_rows[1] = '{32'sd4194304, 1'b1, 1'b1, 32'sd3105306};
    // Extremes: max interval, saturation region, wide gap both ways.
    dir_rows[2] = '{32'sh8000_0000, 1'b0, 1'b0, '0};
    dir_rows[3] = '{32'sh7FFF_FFFF, 1'b0, 1'b0, '0};
    dir_rows[4] = '{32'sh8000_0000, 1'b1, 1'b0, '0};
    // Zero-width interval, small steps, a tick flagged last that is also first.
    dir_rows[5] = '{32'sd100, 1'b1, 1'b0, '0};
    dir_rows[6] = '{32'sd100, 1'b0, 1'b0, '0};
    dir_rows[7] = '{32'sd100, 1'b0, 1'b0, '0};
    dir_rows[8] = '{32'sd101, 1'b0, 1'b0, '0};
    dir_rows[9] = '{-32'sd4194304, 1'b0, 1'b0, '0};
    // Exactly 16 decades, then just above it.
    dir_rows[10] = '{32'sd67108864, 1'b0, 1'b0, '0};
    dir_rows[11] = '{32'sd0, 1'b0, 1'b0, '0};
    dir_rows[12] = '{32'sd67108865, 1'b0, 1'b0, '0};
    dir_rows[13] = '{32'sd0, 1'b1, 1'b0, '0};

    write_count(5'd1);
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].chk) begin
        chk_first_pos = dir_rows[i].want;
        chk_first = 1'b1;
      end
      send_tick(dir_rows[i].pos, dir_rows[i].last);
      if (i == 1) write_count(5'd16);
    end
    write_count(5'd31);
    for (int i = 2; i < 6; i++) send_tick(dir_rows[i].pos, dir_rows[i].last);

    // Random tick sets at several subtick counts, idling on both sides.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_count(5'd0);
        1: write_count(5'd16);
        2: write_count(5'd31);
        3: write_count(5'd17);
        default: write_count(CFG_W'($urandom_range(1, 8)));
      endcase
      stall_mode = phase % 3;
      n_res = 0;
      while (n_res < 46) begin
        last_pos = $urandom_range(1, 8);
        p = $urandom_range(0, 3) == 0 ? PW'($urandom()) :
            PW'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
        for (int k = 0; k < last_pos; k++) begin
          case ($urandom_range(0, 4))
            0: p = PW'($urandom());
            1: p = p + PW'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
            2: p = p + PW'(int'($urandom_range(0, 1 << 16)) - (1 << 15));
            default: p = p + PW'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
          endcase
          send_tick(p, k == last_pos - 1);
          n_res++;
        end
        // Hold off now and then until every subtick has come out.
        if ($urandom_range(0, 9) == 0) begin
          drop_valid();
          @(posedge clk);
          while (expected_subticks.size() != 0) @(posedge clk);
        end
      end
    end

    // Drain.
    drop_valid();
    stall_mode = 0;
    @(posedge clk);
    while (expected_subticks.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS log_axis_subtick_interpolator");
    end else begin
      $display("FAIL log_axis_subtick_interpolator");
    end
    $finish;
  end

endmodule
